>>> design/ipv4_l4_header_parser_unit_assert.svh
// Assertion macros shared by the parser RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef IPV4_L4_HEADER_PARSER_UNIT_ASSERT_SVH
`define IPV4_L4_HEADER_PARSER_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define IP4L4_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ip4l4 invariant violated");

// Consequent holds in the cycle after the antecedent.
`define IP4L4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ip4l4 sequence violated");

`endif

>>> design/ip4l4_pkg.sv
// ----------------------------------------------------------------------------
// ip4l4_pkg
// Types and constants for the Ethernet / IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
package ip4l4_pkg;

  // Byte position counter width
  localparam int CNT_W = 16;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [15:0] HTTP_PORT_RST  = 16'd80;
  localparam logic [15:0] HTTPS_PORT_RST = 16'd443;
  localparam logic [15:0] DNS_PORT_RST   = 16'd53;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_IPV4 = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    APP_UNKNOWN = 3'd0,
    APP_HTTP    = 3'd1,
    APP_HTTPS   = 3'd2,
    APP_DNS     = 3'd3,
    APP_ICMP    = 3'd4
  } app_t;

  typedef enum logic [1:0] {
    CFG_HTTP_PORT  = 2'd0,
    CFG_HTTPS_PORT = 2'd1,
    CFG_DNS_PORT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] ether_kind;
    logic [7:0]  l4_protocol;
    logic [15:0] ip_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    app_t        app_class;
  } out_t;

endpackage

>>> design/ipv4_l4_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser_unit
// Byte-serial Ethernet / IPv4 / TCP-UDP header parser with port classing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per transfer in wire order; last_byte marks the
//           final byte of a frame. Up to one byte is taken every cycle.
//   out_* : one result per frame, produced by the last byte's transfer.
//   cfg_* : register writes (0 http_port, 1 https_port, 2 dns_port);
//           cfg_ready is always high, other indexes are ignored.
// Path: a transferred byte sits in the input register and is parsed there;
//   a last byte's result is loaded into the result register when that byte
//   advances, and is valid on out_* from then on.
// Throughput: one byte per cycle unless a last byte is stalled, set by the
//   single parse stage between the input register and the result register.
// Stall: while a result waits in the output register, non-last bytes keep
//   flowing; a new last byte waits in the input register and in_ready drops
//   until the result is taken.
// Reset: rst_n low clears the frame state, empties both registers and
//   loads the port registers with 80, 443 and 53.
// ----------------------------------------------------------------------------
module ipv4_l4_header_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ip4l4_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ip4l4_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import ip4l4_pkg::*;
  `include "ipv4_l4_header_parser_unit_assert.svh"

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] POS_ETH = CNT_W'(14);

  // Configuration registers
  logic [15:0] http_port_r, https_port_r, dns_port_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // Frame state
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       hdr_words_r, hdr_words_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [15:0]      total_r, total_nxt;
  logic [31:0]      src_addr_r, src_addr_nxt;
  logic [31:0]      dst_addr_r, dst_addr_nxt;
  logic [15:0]      src_port_r, src_port_nxt;
  logic [15:0]      dst_port_r, dst_port_nxt;

  // Captured values including the current byte
  logic [7:0]       cap_hw;
  logic [15:0]      cap_type, cap_total, cap_sport, cap_dport;
  logic [7:0]       cap_proto;
  logic [31:0]      cap_src, cap_dst;
  logic [CNT_W-1:0] pos, rel;
  logic [CNT_W:0]   len;
  logic             cap_en;

  // Output register
  logic out_valid_r;
  out_t out_data_r, res;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      http_port_r  <= HTTP_PORT_RST;
      https_port_r <= HTTPS_PORT_RST;
      dns_port_r   <= DNS_PORT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HTTP_PORT:  http_port_r  <= cfg_data;
        CFG_HTTPS_PORT: https_port_r <= cfg_data;
        CFG_DNS_PORT:   dns_port_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance unless a last byte meets an occupied, stalled output register
  assign s1_adv   = s1_valid_r && !(s1_last_r && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data.data_byte;
      s1_last_r <= in_data.last_byte;
    end
  end

  // Capture the current byte by position
  always_comb begin
    pos       = byte_count_r;
    cap_en    = (pos != CNT_MAX);
    len       = {1'b0, pos} + (CNT_W+1)'(1);
    cap_hw    = hdr_words_r;
    cap_type  = type_r;
    cap_total = total_r;
    cap_proto = proto_r;
    cap_src   = src_addr_r;
    cap_dst   = dst_addr_r;
    cap_sport = src_port_r;
    cap_dport = dst_port_r;
    if (cap_en) begin
      unique case (pos)
        CNT_W'(12): cap_type[15:8]  = s1_byte_r;
        CNT_W'(13): cap_type[7:0]   = s1_byte_r;
        CNT_W'(14): cap_hw = 8'd14 + {2'b00, s1_byte_r[3:0], 2'b00};
        CNT_W'(16): cap_total[15:8] = s1_byte_r;
        CNT_W'(17): cap_total[7:0]  = s1_byte_r;
        CNT_W'(23): cap_proto       = s1_byte_r;
        CNT_W'(26): cap_src[31:24]  = s1_byte_r;
        CNT_W'(27): cap_src[23:16]  = s1_byte_r;
        CNT_W'(28): cap_src[15:8]   = s1_byte_r;
        CNT_W'(29): cap_src[7:0]    = s1_byte_r;
        CNT_W'(30): cap_dst[31:24]  = s1_byte_r;
        CNT_W'(31): cap_dst[23:16]  = s1_byte_r;
        CNT_W'(32): cap_dst[15:8]   = s1_byte_r;
        CNT_W'(33): cap_dst[7:0]    = s1_byte_r;
        default: ;
      endcase
    end
    // L4 ports sit at the first four bytes past the IPv4 header
    rel = pos - CNT_W'(cap_hw);
    if (cap_en && pos >= POS_ETH && pos >= CNT_W'(cap_hw) && rel < CNT_W'(4)) begin
      unique case (rel[1:0])
        2'd0: cap_sport[15:8] = s1_byte_r;
        2'd1: cap_sport[7:0]  = s1_byte_r;
        2'd2: cap_dport[15:8] = s1_byte_r;
        2'd3: cap_dport[7:0]  = s1_byte_r;
        default: ;
      endcase
    end
  end

  // Build the frame result
  always_comb begin
    logic is_tcp, is_udp;
    is_tcp = (cap_proto == PROTO_TCP);
    is_udp = (cap_proto == PROTO_UDP);
    res    = '0;
    res.status    = ST_SHORT;
    res.app_class = APP_UNKNOWN;
    if (len >= (CNT_W+1)'(14)) begin
      res.ether_kind = cap_type;
      if (cap_type != ETYPE_IPV4) begin
        res.status = ST_NOT_IPV4;
      end else if (len >= (CNT_W+1)'(34)) begin
        res.l4_protocol    = cap_proto;
        res.ip_length      = cap_total;
        res.source_address = cap_src;
        res.dest_address   = cap_dst;
        if ((is_tcp && len < (CNT_W+1)'(cap_hw) + (CNT_W+1)'(20)) ||
            (is_udp && len < (CNT_W+1)'(cap_hw) + (CNT_W+1)'(8))) begin
          res.status = ST_SHORT;
        end else begin
          res.status = ST_OK;
          if (is_tcp || is_udp) begin
            res.source_port = cap_sport;
            res.dest_port   = cap_dport;
          end
          priority if (is_tcp) begin
            if (cap_dport == https_port_r)     res.app_class = APP_HTTPS;
            else if (cap_dport == http_port_r) res.app_class = APP_HTTP;
          end else if (is_udp) begin
            if (cap_dport == dns_port_r)       res.app_class = APP_DNS;
          end else if (cap_proto == PROTO_ICMP) begin
            res.app_class = APP_ICMP;
          end else begin
            res.app_class = APP_UNKNOWN;
          end
        end
      end
    end
  end

  // Next frame state: hold, advance, or clear after the last byte
  always_comb begin
    byte_count_nxt = byte_count_r;
    hdr_words_nxt  = hdr_words_r;
    type_nxt       = type_r;
    proto_nxt      = proto_r;
    total_nxt      = total_r;
    src_addr_nxt   = src_addr_r;
    dst_addr_nxt   = dst_addr_r;
    src_port_nxt   = src_port_r;
    dst_port_nxt   = dst_port_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        byte_count_nxt = '0;
        hdr_words_nxt  = '0;
        type_nxt       = '0;
        proto_nxt      = '0;
        total_nxt      = '0;
        src_addr_nxt   = '0;
        dst_addr_nxt   = '0;
        src_port_nxt   = '0;
        dst_port_nxt   = '0;
      end else begin
        byte_count_nxt = cap_en ? pos + CNT_W'(1) : pos;
        hdr_words_nxt  = cap_hw;
        type_nxt       = cap_type;
        proto_nxt      = cap_proto;
        total_nxt      = cap_total;
        src_addr_nxt   = cap_src;
        dst_addr_nxt   = cap_dst;
        src_port_nxt   = cap_sport;
        dst_port_nxt   = cap_dport;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      hdr_words_r  <= '0;
      type_r       <= '0;
      proto_r      <= '0;
      total_r      <= '0;
      src_addr_r   <= '0;
      dst_addr_r   <= '0;
      src_port_r   <= '0;
      dst_port_r   <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      hdr_words_r  <= hdr_words_nxt;
      type_r       <= type_nxt;
      proto_r      <= proto_nxt;
      total_r      <= total_nxt;
      src_addr_r   <= src_addr_nxt;
      dst_addr_r   <= dst_addr_nxt;
      src_port_r   <= src_port_nxt;
      dst_port_r   <= dst_port_nxt;
    end
  end

  // Result register: load on a last byte, drop on an output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `IP4L4_ASSERT_NEXT(a_last_loads_out, s1_adv && s1_last_r, out_valid_r)
  `IP4L4_ASSERT_NEXT(a_last_clears_count, s1_adv && s1_last_r, byte_count_r == '0)
  `IP4L4_ASSERT_ALWAYS(a_stall_cause,
    in_ready || (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
  `IP4L4_ASSERT_NEXT(a_count_monotonic, s1_adv && !s1_last_r,
    byte_count_r >= $past(byte_count_r))

endmodule
